// ----- sv/pck_pkg.sv -----
// pck_pkg: shared constants and controller/datapath interface types
`timescale 1ns / 1ps
package pck_pkg;

  localparam int MAX_TOTAL = 255;
  localparam int COUNT_W   = 64;
  localparam int IN_W      = 8;
  localparam int OUT_W     = 64;

  // table rows and row index
  localparam int DEPTH = MAX_TOTAL + 1;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  // width for index arithmetic, wide enough for any input or row index plus a sign
  localparam int OP_W  = ((AW > IN_W) ? AW : IN_W) + 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef struct packed {
    logic load;       // take a new item
    logic fill_step;  // write a one at the current row
    logic pass_init;  // start a column pass at row j+1
    logic issue;      // read the cell pair for the current row, advance row
    logic next_pass;  // move to the next column
    logic final_rd;   // read the last row
    logic capture;    // latch the last row as the result
  } pck_cmd_t;

  typedef struct packed {
    logic special;      // item settled without the table
    logic fill_done;    // fill is at the last row
    logic pass_empty;   // current column has no cell to update
    logic issue_last;   // pass is at the last row
    logic passes_done;  // all columns built
  } pck_stat_t;

endpackage

// ----- sv/pck_ctrl.sv -----
// pck_ctrl: sequencer for table fill, column passes and result capture
`timescale 1ns / 1ps
module pck_ctrl
  import pck_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  pck_stat_t stat_i,
  output pck_cmd_t  cmd_o
);

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_FILL    = 7'b0000010,
    ST_NEXT    = 7'b0000100,
    ST_PASS    = 7'b0001000,
    ST_DRAIN   = 7'b0010000,
    ST_FINAL   = 7'b0100000,
    ST_CAPTURE = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = stat_i.special ? ST_IDLE : ST_FILL;
        end
      end
      ST_FILL: begin
        cmd_o.fill_step = 1'b1;
        if (stat_i.fill_done) begin
          state_d = ST_NEXT;
        end
      end
      ST_NEXT: begin
        // once a column is empty every later one is too
        if (stat_i.passes_done || stat_i.pass_empty) begin
          state_d = ST_FINAL;
        end else begin
          cmd_o.pass_init = 1'b1;
          state_d         = ST_PASS;
        end
      end
      ST_PASS: begin
        cmd_o.issue = 1'b1;
        if (stat_i.issue_last) begin
          cmd_o.next_pass = 1'b1;
          state_d         = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last write of the column lands here
        state_d = ST_NEXT;
      end
      ST_FINAL: begin
        cmd_o.final_rd = 1'b1;
        state_d        = ST_CAPTURE;
      end
      ST_CAPTURE: begin
        cmd_o.capture = 1'b1;
        state_d       = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != ST_IDLE);

endmodule

// ----- sv/pck_datapath.sv -----
// pck_datapath: table memory, row/column counters, saturating adder, result registers
`timescale 1ns / 1ps
module pck_datapath
  import pck_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [IN_W-1:0]    total_value_i,
  input  logic [IN_W-1:0]    part_count_i,
  input  pck_cmd_t           cmd_i,
  output pck_stat_t          stat_o,
  output logic [OUT_W-1:0]   partition_count_o,
  output logic               saturated_o,
  output logic               done_o
);

  logic [COUNT_W-1:0] mem_q [DEPTH];

  logic [AW-1:0]      last_q;
  logic [IN_W-1:0]    k_q;
  logic [IN_W-1:0]    j_q;
  logic [AW-1:0]      i_q;
  logic               wv_q;
  logic [AW-1:0]      wa_q;
  logic [COUNT_W-1:0] rd_a_q, rd_b_q;
  logic [COUNT_W-1:0] res_q;
  logic               sat_q;
  logic               over_q;
  logic               done_q;

  logic [OP_W-1:0]    n_ext, k_ext, j_ext, i_ext, last_ext;
  logic [AW-1:0]      ra, rb;
  logic [COUNT_W:0]   sum_full;
  logic [COUNT_W-1:0] sum;
  logic               carry;
  logic               special;
  logic               spec_sat;
  logic [COUNT_W-1:0] spec_cnt;

  assign n_ext    = OP_W'(total_value_i);
  assign k_ext    = OP_W'(part_count_i);
  assign j_ext    = OP_W'(j_q);
  assign i_ext    = OP_W'(i_q);
  assign last_ext = OP_W'(last_q);

  // settle degenerate items without the table
  always_comb begin
    special  = 1'b1;
    spec_cnt = '0;
    spec_sat = 1'b0;
    if (n_ext < k_ext) begin
      spec_cnt = '0;
    end else if (total_value_i == '0 && part_count_i == '0) begin
      spec_cnt = COUNT_W'(1);
    end else if (part_count_i == '0) begin
      spec_cnt = '0;
    end else if (n_ext > OP_W'(MAX_TOTAL)) begin
      spec_sat = 1'b1;
    end else begin
      special = 1'b0;
    end
  end

  assign stat_o.special     = special;
  assign stat_o.fill_done   = (i_q == last_q);
  assign stat_o.issue_last  = (i_q == last_q);
  assign stat_o.pass_empty  = ((j_ext + OP_W'(1)) > last_ext);
  assign stat_o.passes_done = (j_q == k_q);

  // col_j[i] += col_j[i-j-1]
  assign ra = cmd_i.final_rd ? last_q : i_q;
  assign rb = AW'(i_ext - j_ext - OP_W'(1));

  assign sum_full = {1'b0, rd_a_q} + {1'b0, rd_b_q};
  assign carry    = sum_full[COUNT_W];
  assign sum      = carry ? COUNT_MAX : sum_full[COUNT_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.fill_step) begin
      mem_q[i_q] <= COUNT_W'(1);
    end else if (wv_q) begin
      mem_q[wa_q] <= sum;
    end
    rd_a_q <= mem_q[ra];
    rd_b_q <= mem_q[rb];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      last_q <= AW'(n_ext - k_ext);
      k_q    <= part_count_i;
    end
    if (cmd_i.load && special) begin
      res_q <= spec_cnt;
      sat_q <= spec_sat;
    end else if (cmd_i.capture) begin
      res_q <= rd_a_q;
      sat_q <= over_q;
    end
    wa_q <= i_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q    <= '0;
      j_q    <= '0;
      wv_q   <= 1'b0;
      over_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      wv_q   <= cmd_i.issue;
      done_q <= (cmd_i.load && special) || cmd_i.capture;
      if (cmd_i.load) begin
        i_q    <= '0;
        j_q    <= IN_W'(1);
        over_q <= 1'b0;
      end else begin
        if (cmd_i.pass_init) begin
          i_q <= AW'(j_ext + OP_W'(1));
        end else if (cmd_i.fill_step || cmd_i.issue) begin
          i_q <= i_q + AW'(1);
        end
        if (cmd_i.next_pass) begin
          j_q <= j_q + IN_W'(1);
        end
        if (wv_q && carry) begin
          over_q <= 1'b1;
        end
      end
    end
  end

  assign partition_count_o = OUT_W'(res_q);
  assign saturated_o       = sat_q;
  assign done_o            = done_q;

endmodule

// ----- sv/partition_count_k_parts.sv -----
// partition_count_k_parts: counts partitions of a total into exactly k positive parts
//
//   channel   handshake              payload
//   request   start / busy           total_value_i, part_count_i
//   result    done_o (one cycle)     partition_count_o, saturated_o
//
// an item is taken when start is high and busy is low; a degenerate item has its result
// in the next cycle; otherwise the table is filled with ones, then a column pass runs for
// each j from 1 to min(k-1, n-k-1), then the last row is read and captured; the table
// memory builds one cell each cycle within the fill and each pass, column by column.
// reset is asynchronous, active low; the table needs no clearing pass.
// done is high for one cycle and cannot be held off; busy falls as the result appears.
`timescale 1ns / 1ps
module partition_count_k_parts
  import pck_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [IN_W-1:0]    total_value_i,
  input  logic [IN_W-1:0]    part_count_i,
  output logic [OUT_W-1:0]   partition_count_o,
  output logic               saturated_o,
  output logic               done_o
);

  pck_cmd_t  cmd;
  pck_stat_t stat;

  pck_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  pck_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .total_value_i     (total_value_i),
    .part_count_i      (part_count_i),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .partition_count_o (partition_count_o),
    .saturated_o       (saturated_o),
    .done_o            (done_o)
  );

endmodule
